// ===== rtl/core/bdslp_pkg.sv =====
// Shared types, constants and register codes for the button press detector.
package bdslp_pkg;

  localparam int unsigned MAX_BUTTONS      = 2;
  localparam int unsigned NUM_BUTTONS_DEF  = 2;

  localparam int unsigned DEB_W   = 12;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic               ACTIVE_LOW_RST = 1'b1;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = DEB_W'(35);
  localparam logic [TIMER_W-1:0] LONG_RST       = TIMER_W'(450);
  localparam logic [CNT_W-1:0]   BTN_COUNT_RST  = CNT_W'(1);

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LOW   = 2'd0,
    REG_DEBOUNCE     = 2'd1,
    REG_LONG_TICKS   = 2'd2,
    REG_BUTTON_COUNT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_TRACK = 2'd2,
    PH_FIRED = 2'd3
  } phase_e;

  typedef struct packed {
    logic               active_low;
    logic [DEB_W-1:0]   debounce_ticks;
    logic [TIMER_W-1:0] long_ticks;
  } btn_cfg_t;

  typedef struct packed {
    logic ev_short;
    logic ev_long;
    logic held;
  } btn_evt_t;

endpackage

// ===== rtl/core/bdslp_if.sv =====
// Valid/ready channel interfaces: button tick input, event output, register write.
interface bdslp_in_if;
  logic valid;
  logic ready;
  logic level_first;
  logic level_second;

  modport source (output valid, output level_first, output level_second, input ready);
  modport sink   (input valid, input level_first, input level_second, output ready);
endinterface

interface bdslp_out_if;
  logic valid;
  logic ready;
  logic short_first;
  logic long_first;
  logic short_second;
  logic long_second;
  logic held_first;
  logic held_second;

  modport source (output valid, output short_first, output long_first,
                  output short_second, output long_second,
                  output held_first, output held_second, input ready);
  modport sink   (input valid, input short_first, input long_first,
                  input short_second, input long_second,
                  input held_first, input held_second, output ready);
endinterface

interface bdslp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [15:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== rtl/core/bdslp_button.sv =====
// Per-button debounce, hold timer and short/long press state machine.
module bdslp_button (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,     // tick moves to the result register
  input  logic                in_use_i,
  input  logic                down_i,
  input  bdslp_pkg::btn_cfg_t cfg_i,
  output bdslp_pkg::btn_evt_t evt_o
);
  import bdslp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [TIMER_W-1:0] timer_inc;

  assign timer_inc = (timer_q == TIMER_MAX) ? timer_q : timer_q + TIMER_W'(1);

  always_comb begin
    phase_d        = phase_q;
    timer_d        = timer_q;
    evt_o.ev_short = 1'b0;
    evt_o.ev_long  = 1'b0;
    if (!in_use_i) begin
      phase_d = PH_IDLE;
      timer_d = '0;
    end else begin
      unique case (phase_q)
        PH_WAIT: begin
          if (timer_q > TIMER_W'(1)) begin
            timer_d = timer_q - TIMER_W'(1);
          end else begin
            phase_d = down_i ? PH_TRACK : PH_IDLE;
            timer_d = '0;
          end
        end
        PH_TRACK: begin
          if (!down_i) begin
            evt_o.ev_short = 1'b1;
            phase_d        = PH_IDLE;
            timer_d        = '0;
          end else begin
            timer_d = timer_inc;
            if (timer_inc >= cfg_i.long_ticks) begin
              evt_o.ev_long = 1'b1;
              phase_d       = PH_FIRED;
            end
          end
        end
        PH_FIRED: begin
          if (!down_i) begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end else begin
            timer_d = timer_inc;
          end
        end
        PH_IDLE: begin
          timer_d = '0;
          if (down_i) begin
            if (cfg_i.debounce_ticks == '0) begin
              phase_d = PH_TRACK;
            end else begin
              phase_d = PH_WAIT;
              timer_d = TIMER_W'(cfg_i.debounce_ticks);
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          timer_d = '0;
        end
      endcase
    end
    evt_o.held = in_use_i && ((phase_d == PH_TRACK) || (phase_d == PH_FIRED));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
    end
  end

endmodule

// ===== rtl/core/button_debounce_short_long_press_core.sv =====
// Top level: debounced short/long press detector for up to two buttons.
//
// Channels:
//   in_i  - one beat per sampling tick, carrying the raw level of each button.
//   out_o - one beat per input beat: short/long events and held flags.
//   cfg_i - register writes (0 polarity, 1 debounce ticks, 2 long ticks,
//           3 button count); always ready, takes effect on the next tick.
// Path: an input beat passes through the input register, then the result
//   register, and shows on out_o from the result register; a stall on out_o
//   can hold it in the input register.
// Throughput: one beat per cycle while out_o is ready; each button's update is
//   a single 16-bit increment and compare between input and result registers.
// Reset: every button idle with its timer cleared, registers at defaults
//   (active low, 35 debounce ticks, 450 long ticks, one button), no beat held.
// Stall: when out_o is not ready the result register holds its beat; the
//   input register still takes one more tick, then in_i.ready drops until
//   the result is taken. Button state advances only as a tick moves on to the
//   result register, so stalls never skip or repeat a tick.
module button_debounce_short_long_press_core #(
  parameter int unsigned NUM_BUTTONS = bdslp_pkg::NUM_BUTTONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdslp_in_if.sink    in_i,
  bdslp_out_if.source out_o,
  bdslp_cfg_if.sink   cfg_i
);
  import bdslp_pkg::*;

  // ---- configuration registers ----
  logic               active_low_q;
  logic [DEB_W-1:0]   debounce_q;
  logic [TIMER_W-1:0] long_ticks_q;
  logic [CNT_W-1:0]   btn_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= ACTIVE_LOW_RST;
      debounce_q   <= DEBOUNCE_RST;
      long_ticks_q <= LONG_RST;
      btn_count_q  <= BTN_COUNT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (reg_idx_e'(cfg_i.idx))
        REG_ACTIVE_LOW:   active_low_q <= cfg_i.data[0];
        REG_DEBOUNCE:     debounce_q   <= cfg_i.data[DEB_W-1:0];
        REG_LONG_TICKS:   long_ticks_q <= cfg_i.data[TIMER_W-1:0];
        REG_BUTTON_COUNT: btn_count_q  <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  btn_cfg_t btn_cfg;
  assign btn_cfg.active_low     = active_low_q;
  assign btn_cfg.debounce_ticks = debounce_q;
  assign btn_cfg.long_ticks     = long_ticks_q;

  // Count of 0 means 1; anything past the built buttons is clamped.
  logic [CNT_W-1:0] count_eff;
  always_comb begin
    priority if (btn_count_q == '0) begin
      count_eff = CNT_W'(1);
    end else if (btn_count_q > CNT_W'(NUM_BUTTONS)) begin
      count_eff = CNT_W'(NUM_BUTTONS);
    end else begin
      count_eff = btn_count_q;
    end
  end

  // ---- input register ----
  logic                   s1_valid_q;
  logic [MAX_BUTTONS-1:0] s1_level_q;
  logic                   out_valid_q;
  logic                   out_adv;     // tick in s1 moves to the result register

  assign out_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (out_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_level_q <= {in_i.level_second, in_i.level_first};
    end
  end

  // ---- per-button units ----
  btn_evt_t evt [MAX_BUTTONS];

  for (genvar b = 0; b < MAX_BUTTONS; b++) begin : g_btn
    if (b < NUM_BUTTONS) begin : g_used
      bdslp_button u_btn (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .adv_i    (out_adv),
        .in_use_i (CNT_W'(b) < count_eff),
        .down_i   (s1_level_q[b] ^ active_low_q),
        .cfg_i    (btn_cfg),
        .evt_o    (evt[b])
      );
    end else begin : g_absent
      assign evt[b] = '0;
    end
  end

  // ---- result register ----
  btn_evt_t res_q [MAX_BUTTONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      res_q <= evt;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.short_first  = res_q[0].ev_short;
  assign out_o.long_first   = res_q[0].ev_long;
  assign out_o.held_first   = res_q[0].held;
  assign out_o.short_second = res_q[1].ev_short;
  assign out_o.long_second  = res_q[1].ev_long;
  assign out_o.held_second  = res_q[1].held;

  // ---- checks ----
  // A tick cannot give both a short and a long event for one button.
  a_no_short_and_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q[0].ev_short && res_q[0].ev_long)
                 && !(res_q[1].ev_short && res_q[1].ev_long))
    else $error("short and long event on the same tick");

  // Long fires while still held; short means the button was released.
  a_event_vs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!res_q[0].ev_long || res_q[0].held)
                 && (!res_q[0].ev_short || !res_q[0].held))
    else $error("event and held flag disagree");

  // An empty result register never back-pressures the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // A tick that leaves the input register is held in the result register
  // on the next cycle.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_adv |=> out_valid_q)
    else $error("tick did not advance to result register");

endmodule

// ===== sim/button_debounce_short_long_press_core_tb.sv =====
// Testbench for the short/long press detector: directed table, random press runs, predictor check.
`timescale 1ns / 100ps

module button_debounce_short_long_press_core_tb;
  import bdslp_pkg::*;

  // Run limits. The slowest legal run is roughly 600 items, and the cycle limit
  // sits above what such a run takes.
  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned DRAIN_CYCLES = 8;      // two-stage pipe, with margin
  localparam int unsigned NUM_BTN      = NUM_BUTTONS_DEF;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned FINAL_TICKS  = 48;

  // One result beat. The field order matches the output list.
  typedef struct packed {
    logic short_first;
    logic long_first;
    logic short_second;
    logic long_second;
    logic held_first;
    logic held_second;
  } press_result_t;

  typedef enum bit {ROW_TICK, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    reg_idx_e               idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   lvl_first;
    logic                   lvl_second;
    bit                     typed;      // 1: want is given, else predictor
    press_result_t          want;
  } stim_row_t;

  // Directed part. The want column is ordered sf lf ss ls hf hs.
  localparam int NUM_DIRECTED = 36;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // reset defaults: active low, button 2 unused
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b1, 1'b1, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b0, 1'b1, 6'b000000},
    // active high, no debounce, long at 2 holds, both buttons
    '{ROW_REG,  REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_REG,  REG_DEBOUNCE,     16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_REG,  REG_LONG_TICKS,   16'd2, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_REG,  REG_BUTTON_COUNT, 16'd2, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b0, 1'b1, 6'b000010},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b1, 1'b1, 6'b000011},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b1, 1'b1, 6'b010011},
    // release after long is silent; release in track is short
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b1, 6'b001000},
    // long threshold zero: fires on the first hold tick after confirm
    '{ROW_REG,  REG_LONG_TICKS,   16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b0, 1'b1, 6'b000010},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b0, 1'b1, 6'b010010},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b1, 6'b000000},
    // one-tick debounce: bounce, then confirm and a quick release
    '{ROW_REG,  REG_DEBOUNCE,     16'd1, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b0, 1'b1, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b1, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b1, 1'b1, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b1, 1'b1, 6'b000001},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b1, 6'b001000},
    // count 0 acts as 1; back to active low
    '{ROW_REG,  REG_ACTIVE_LOW,   16'd1, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_REG,  REG_BUTTON_COUNT, 16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b1, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b1, 6'b000010},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b1, 1'b1, 6'b100000},
    // count 3 is clamped to 2; these rows are checked by the predictor
    '{ROW_REG,  REG_BUTTON_COUNT, 16'd3, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_REG,  REG_LONG_TICKS,   16'd3, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_REG,  REG_DEBOUNCE,     16'd2, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b1, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b0, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b0, 1'b0, 6'b000000},
    '{ROW_TICK, REG_ACTIVE_LOW,   16'd0, 1'b1, 1'b1, 1'b0, 6'b000000}
  };

  logic clk_i;
  logic rst_ni;

  bdslp_in_if  in_if ();
  bdslp_out_if out_if ();
  bdslp_cfg_if cfg_if ();

  button_debounce_short_long_press_core #(
    .NUM_BUTTONS(NUM_BTN)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Register copies used by the predictor. They are updated at the write beat.
  logic               cfg_active_low;
  logic [DEB_W-1:0]   cfg_debounce;
  logic [TIMER_W-1:0] cfg_long;
  logic [CNT_W-1:0]   cfg_count;

  // Per-button state kept by the predictor.
  phase_e             btn_phase [2];
  logic [TIMER_W-1:0] btn_timer [2];

  // Random press-run generator: the current logical level and the ticks left in this run.
  bit          press_down [2];
  int unsigned press_left [2];

  press_result_t pending_events [$];
  int unsigned   mismatch_count;
  int unsigned   result_count;
  int unsigned   cycle_count;
  int unsigned   gap_pct;        // sender idle chance per beat, percent
  int unsigned   stall_pct;      // receiver stall chance per cycle, percent

  // Field names indexed by bit position in press_result_t.
  string field_names [6] = '{"held_second", "held_first", "long_second",
                             "short_second", "long_first", "short_first"};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] beat %0d: %s", $time, result_count, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Advances one button by one tick.
  function automatic void step_button(input int b, input logic down,
                                      output logic ev_short, output logic ev_long);
    ev_short = 1'b0;
    ev_long  = 1'b0;
    case (btn_phase[b])
      PH_WAIT: begin
        // The level is not looked at until the last wait tick.
        if (btn_timer[b] > 1) begin
          btn_timer[b] = btn_timer[b] - 1'b1;
        end else if (down) begin
          btn_phase[b] = PH_TRACK;
          btn_timer[b] = '0;
        end else begin
          btn_phase[b] = PH_IDLE;   // bounce
          btn_timer[b] = '0;
        end
      end
      PH_TRACK: begin
        if (!down) begin
          ev_short     = 1'b1;
          btn_phase[b] = PH_IDLE;
          btn_timer[b] = '0;
        end else begin
          if (btn_timer[b] != TIMER_MAX) btn_timer[b] = btn_timer[b] + 1'b1;
          if (btn_timer[b] >= cfg_long) begin
            ev_long      = 1'b1;
            btn_phase[b] = PH_FIRED;
          end
        end
      end
      PH_FIRED: begin
        if (!down) begin
          btn_phase[b] = PH_IDLE;
          btn_timer[b] = '0;
        end else if (btn_timer[b] != TIMER_MAX) begin
          btn_timer[b] = btn_timer[b] + 1'b1;
        end
      end
      default: begin
        btn_phase[b] = PH_IDLE;
        btn_timer[b] = '0;
        if (down) begin
          // Zero debounce confirms on the first down sample.
          if (cfg_debounce == '0) begin
            btn_phase[b] = PH_TRACK;
          end else begin
            btn_phase[b] = PH_WAIT;
            btn_timer[b] = TIMER_W'(cfg_debounce);
          end
        end
      end
    endcase
  endfunction

  // Expected result of one sampling tick. This also advances the state copy.
  function automatic press_result_t predict_events(input logic lvl_first,
                                                   input logic lvl_second);
    press_result_t res;
    int unsigned   in_use;
    logic          lvl [2];
    logic          ev_s;
    logic          ev_l;
    logic          held;
    res    = '0;
    lvl[0] = lvl_first;
    lvl[1] = lvl_second;
    in_use = cfg_count;
    if (in_use < 1) in_use = 1;
    if (in_use > NUM_BTN) in_use = NUM_BTN;
    for (int b = 0; b < 2; b++) begin
      if (b < in_use) begin
        step_button(b, cfg_active_low ? !lvl[b] : lvl[b], ev_s, ev_l);
        held = (btn_phase[b] == PH_TRACK) || (btn_phase[b] == PH_FIRED);
        if (b == 0) begin
          res.short_first = ev_s;
          res.long_first  = ev_l;
          res.held_first  = held;
        end else begin
          res.short_second = ev_s;
          res.long_second  = ev_l;
          res.held_second  = held;
        end
      end else begin
        // An unused button is held idle.
        btn_phase[b] = PH_IDLE;
        btn_timer[b] = '0;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Each task is entered at a falling edge and returns at one.
  // ---------------------------------------------------------------------------

  // Sends one tick. When typed is set, want is queued instead of the prediction.
  task automatic send_tick(input logic lvl_first, input logic lvl_second,
                           input bit typed, input press_result_t want);
    press_result_t model;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.level_first  <= lvl_first;
    in_if.level_second <= lvl_second;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    model = predict_events(lvl_first, lvl_second);
    pending_events.push_back(typed ? want : model);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every expected beat has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_events.size() != 0);
  endtask

  // Register write. Only called while the pipe is empty.
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_ACTIVE_LOW:   cfg_active_low = data[0];
      REG_DEBOUNCE:     cfg_debounce   = data[DEB_W-1:0];
      REG_LONG_TICKS:   cfg_long       = data[TIMER_W-1:0];
      REG_BUTTON_COUNT: cfg_count      = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Next raw level of one button. Presses are sized around the current
  // debounce and long settings: a bounce, a short press, or a press that
  // holds past long. Releases are short. About 8% of ticks are pure noise.
  function automatic logic next_level(input int b);
    int unsigned d;
    int unsigned l;
    d = cfg_debounce;
    l = cfg_long;
    if (press_left[b] == 0) begin
      press_down[b] = !press_down[b];
      if (!press_down[b]) begin
        press_left[b] = $urandom_range(1, 4);
      end else begin
        case ($urandom_range(0, 2))
          0:       press_left[b] = $urandom_range(1, (d > 0) ? d : 1);
          1:       press_left[b] = $urandom_range(d + 1, d + ((l > 0) ? l : 1));
          default: press_left[b] = $urandom_range(d + l + 1, d + l + 4);
        endcase
      end
    end
    press_left[b]--;
    if ($urandom_range(0, 99) < 8) return 1'($urandom_range(0, 1));
    return cfg_active_low ? !press_down[b] : press_down[b];
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready stalls, and the checker
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Values are read at the rising edge before the block's own updates land.
  always @(posedge clk_i) begin
    press_result_t got;
    press_result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = {out_if.short_first, out_if.long_first, out_if.short_second,
             out_if.long_second, out_if.held_first, out_if.held_second};
      if (pending_events.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_events.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (got[f] !== want[f]) begin
            report_mismatch($sformatf("%s got %b want %b", field_names[f], got[f], want[f]));
          end
        end
      end
      result_count++;
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    // Every input is known from time zero.
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.level_first   = 1'b0;
    in_if.level_second  = 1'b0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.idx          = REG_ACTIVE_LOW;
    cfg_if.data         = '0;
    mismatch_count      = 0;
    result_count        = 0;
    gap_pct             = 15;
    stall_pct           = 15;
    press_down          = '{1'b0, 1'b0};
    press_left          = '{0, 0};

    // Predictor at reset values
    cfg_active_low = ACTIVE_LOW_RST;
    cfg_debounce   = DEBOUNCE_RST;
    cfg_long       = LONG_RST;
    cfg_count      = BTN_COUNT_RST;
    btn_phase      = '{PH_IDLE, PH_IDLE};
    btn_timer      = '{'0, '0};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. Register rows wait for the pipe to empty first.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_REG) begin
        wait_drained();
        write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].data);
      end else begin
        send_tick(DIRECTED_ROWS[r].lvl_first, DIRECTED_ROWS[r].lvl_second,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
    end

    // Random phases. Each one starts from an empty pipe with a fresh setting.
    // Phase 0 has zero debounce and phase 1 has a long threshold of one.
    // Every third phase runs with no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_reg(REG_ACTIVE_LOW,   CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(REG_DEBOUNCE,     (p == 0) ? '0 : CFG_DATA_W'($urandom_range(0, 6)));
      write_reg(REG_LONG_TICKS,   (p == 1) ? CFG_DATA_W'(1) : CFG_DATA_W'($urandom_range(0, 12)));
      write_reg(REG_BUTTON_COUNT, CFG_DATA_W'($urandom_range(0, 3)));
      gap_pct   = (p % 3 == 0) ? 0 : $urandom_range(5, 30);
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 30);
      repeat ($urandom_range(60, 75)) begin
        // Now and then the sender waits for every result to return.
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_tick(next_level(0), next_level(1), 1'b0, '0);
      end
    end

    // Last part, with no idling on either side: both buttons in use under a
    // fresh setting.
    wait_drained();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(REG_ACTIVE_LOW,   CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(REG_DEBOUNCE,     CFG_DATA_W'($urandom_range(1, 6)));
    write_reg(REG_LONG_TICKS,   CFG_DATA_W'($urandom_range(2, 12)));
    write_reg(REG_BUTTON_COUNT, CFG_DATA_W'(2));
    repeat (FINAL_TICKS) begin
      send_tick(next_level(0), next_level(1), 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never came", pending_events.size()));
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
